// ----- rtl/rau_pkg.sv -----
package rau_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned ProdBits = 2 * WordBits;
  localparam int unsigned SumBits  = ProdBits + 1;
  localparam int unsigned QDepth   = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_CMP = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               equal;
    logic               div_by_zero;
    logic               overflow;
  } out_t;

  // Classified request handed from front to back.
  typedef struct packed {
    logic                bypass;   // result already final (compare, divide by zero)
    out_t                early;
    op_e                 op;
    logic                an_neg;
    logic [WordBits-1:0] an_mag;
    logic                ad_neg;
    logic [WordBits-1:0] ad_mag;
    logic                bn_neg;
    logic [WordBits-1:0] bn_mag;
    logic                bd_neg;
    logic [WordBits-1:0] bd_mag;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_FIN,
    ST_OUT
  } st_e;

endpackage

// ----- rtl/rau_front.sv -----
module rau_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::in_t  req_i,
  input  logic          push_i,
  output logic          full_o,
  output rau_pkg::job_t job_o,
  output logic          job_vld_o,
  input  logic          job_rdy_i
);

  localparam int unsigned W = rau_pkg::WordBits;

  rau_pkg::job_t q_mem [rau_pkg::QDepth];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  rau_pkg::job_t job;
  logic          wr_en, rd_en;
  logic          eq;
  logic [W-1:0]  an, ad, bn, bd;

  always_comb begin
    an = req_i.a_num[W-1:0];
    ad = req_i.a_den[W-1:0];
    bn = req_i.b_num[W-1:0];
    bd = req_i.b_den[W-1:0];
    eq = (an == bn) && (ad == bd);
    job        = '0;
    job.op     = rau_pkg::op_e'(req_i.operation);
    job.an_neg = an[W-1];
    job.an_mag = an[W-1] ? (~an + W'(1)) : an;
    job.ad_neg = ad[W-1];
    job.ad_mag = ad[W-1] ? (~ad + W'(1)) : ad;
    job.bn_neg = bn[W-1];
    job.bn_mag = bn[W-1] ? (~bn + W'(1)) : bn;
    job.bd_neg = bd[W-1];
    job.bd_mag = bd[W-1] ? (~bd + W'(1)) : bd;
    if (job.op == rau_pkg::OP_CMP) begin
      job.bypass      = 1'b1;
      job.early.equal = eq;
    end else if (job.op == rau_pkg::OP_DIV && bn == '0) begin
      job.bypass            = 1'b1;
      job.early.div_by_zero = 1'b1;
    end
  end

  assign full_o    = (cnt_q == 2'(rau_pkg::QDepth));
  assign job_vld_o = (cnt_q != 2'd0);
  assign wr_en     = push_i && !full_o;
  assign rd_en     = job_vld_o && job_rdy_i;
  assign job_o     = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + wr_en;
    rd_ptr_d = rd_ptr_q + rd_en;
    cnt_d    = cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/rau_back.sv -----
module rau_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rau_pkg::job_t job_i,
  input  logic          job_vld_i,
  output logic          job_rdy_o,
  output rau_pkg::out_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);

  localparam int unsigned W  = rau_pkg::WordBits;
  localparam int unsigned P  = rau_pkg::ProdBits;
  localparam int unsigned CB = $clog2(P + 1);

  rau_pkg::st_e   st_q, st_d;
  rau_pkg::job_t  job_q;
  logic [P-1:0]   p_q, p_d;       // product register
  logic [P-1:0]   t_q, t_d;       // first cross product
  logic           t_neg_q, t_neg_d;
  logic [P-1:0]   num_q, num_d, den_q, den_d;
  logic           num_neg_q, num_neg_d, den_neg_q, den_neg_d;
  logic [P-1:0]   x_q, x_d, y_q, y_d;      // gcd remainder pair
  logic [P-1:0]   dv_q, dv_d;              // divisor (gcd)
  logic [P-1:0]   rem_q, rem_d, quo_q, quo_d, dnd_q, dnd_d;
  logic [CB-1:0]  cnt_q, cnt_d;
  logic           dstart_q, dstart_d;
  rau_pkg::out_t  res_q, res_d;
  logic [P:0]     trial;
  logic [P-1:0]   rem_sh;
  logic [W-1:0]   mul_a, mul_b;
  logic [P-1:0]   mul_p;
  logic           mul_neg;

  function automatic logic fits(input logic neg, input logic [P-1:0] mag);
    logic [P-1:0] lim;
    lim = P'(1) << (W - 1);
    return neg ? (mag <= lim) : (mag < lim);
  endfunction

  function automatic logic [31:0] to_field(input logic neg, input logic [P-1:0] mag);
    logic [W-1:0] t;
    t = neg ? (W'(~mag) + W'(1)) : mag[W-1:0];
    return 32'(signed'(t));
  endfunction

  // One shared multiplier; operands chosen by step.
  always_comb begin
    mul_a = job_q.an_mag; mul_b = job_q.bd_mag;
    mul_neg = job_q.an_neg ^ job_q.bd_neg;
    case (st_q)
      rau_pkg::ST_MUL0: begin
        if (job_q.op == rau_pkg::OP_MUL) begin
          mul_b = job_q.bn_mag; mul_neg = job_q.an_neg ^ job_q.bn_neg;
        end
      end
      rau_pkg::ST_MUL1: begin
        if (job_q.op == rau_pkg::OP_DIV) begin
          mul_a = job_q.ad_mag; mul_b = job_q.bn_mag;
          mul_neg = job_q.ad_neg ^ job_q.bn_neg;
        end else begin
          mul_a = job_q.ad_mag; mul_b = job_q.bd_mag;
          mul_neg = job_q.ad_neg ^ job_q.bd_neg;
        end
      end
      rau_pkg::ST_MUL2: begin
        mul_a = job_q.bn_mag; mul_b = job_q.ad_mag;
        mul_neg = job_q.bn_neg ^ job_q.ad_neg;
      end
      default: ;
    endcase
    mul_p = P'(mul_a) * P'(mul_b);
  end

  assign rem_sh = {rem_q[P-2:0], dnd_q[P-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dv_q};

  always_comb begin
    st_d = st_q;
    case (st_q)
      rau_pkg::ST_IDLE: if (job_vld_i) st_d = rau_pkg::ST_MUL0;
      rau_pkg::ST_MUL0: st_d = job_q.bypass ? rau_pkg::ST_OUT : rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: st_d = (job_q.op == rau_pkg::OP_ADD) ? rau_pkg::ST_MUL2
                                                            : rau_pkg::ST_SUM;
      rau_pkg::ST_MUL2: st_d = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM:  st_d = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD: begin
        if (y_q == '0 && !dstart_q) st_d = (x_q > P'(1)) ? rau_pkg::ST_DIVN : rau_pkg::ST_FIN;
      end
      rau_pkg::ST_DIVN: if (cnt_q == CB'(P)) st_d = rau_pkg::ST_DIVD;
      rau_pkg::ST_DIVD: if (cnt_q == CB'(P)) st_d = rau_pkg::ST_FIN;
      rau_pkg::ST_FIN:  st_d = rau_pkg::ST_OUT;
      rau_pkg::ST_OUT:  if (pop_i) st_d = rau_pkg::ST_IDLE;
      default:          st_d = rau_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    p_d = p_q; t_d = t_q; t_neg_d = t_neg_q;
    num_d = num_q; den_d = den_q; num_neg_d = num_neg_q; den_neg_d = den_neg_q;
    x_d = x_q; y_d = y_q; dv_d = dv_q; rem_d = rem_q; quo_d = quo_q; dnd_d = dnd_q;
    cnt_d = cnt_q; dstart_d = dstart_q; res_d = res_q;
    case (st_q)
      rau_pkg::ST_MUL0: begin
        t_d = mul_p; t_neg_d = mul_neg && (mul_p != '0);
        res_d = job_q.early;
      end
      rau_pkg::ST_MUL1: begin
        den_d = mul_p; den_neg_d = mul_neg && (mul_p != '0);
        num_d = t_q; num_neg_d = t_neg_q;
      end
      rau_pkg::ST_MUL2: begin
        p_d = mul_p; num_neg_d = mul_neg && (mul_p != '0);
      end
      rau_pkg::ST_SUM: begin
        if (job_q.op == rau_pkg::OP_ADD) begin
          // signed-magnitude add of t (sign t_neg) and p (sign num_neg)
          if (t_neg_q == num_neg_q) begin
            num_d = t_q + p_q; num_neg_d = t_neg_q;
          end else if (t_q >= p_q) begin
            num_d = t_q - p_q; num_neg_d = t_neg_q;
          end else begin
            num_d = p_q - t_q;
          end
          if (num_d == '0) num_neg_d = 1'b0;
          x_d = num_d;
        end else begin
          x_d = num_q;
        end
        y_d = den_q;
        dstart_d = 1'b0;
      end
      rau_pkg::ST_GCD: begin
        // Euclid: each remainder via a bit-serial divider.
        if (!dstart_q) begin
          if (y_q == '0) begin
            dv_d = x_q; dnd_d = num_q; rem_d = '0; quo_d = '0; cnt_d = '0;
          end else begin
            dv_d = y_q; dnd_d = x_q; rem_d = '0; quo_d = '0; cnt_d = '0;
            dstart_d = 1'b1;
          end
        end else if (cnt_q == CB'(P)) begin
          x_d = y_q; y_d = rem_q; dstart_d = 1'b0;
        end else begin
          rem_d = trial[P] ? rem_sh : trial[P-1:0];
          dnd_d = {dnd_q[P-2:0], 1'b0};
          cnt_d = cnt_q + CB'(1);
        end
      end
      rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
        if (cnt_q == CB'(P)) begin
          if (st_q == rau_pkg::ST_DIVN) begin
            num_d = quo_q; dnd_d = den_q;
          end else begin
            den_d = quo_q;
          end
          rem_d = '0; quo_d = '0; cnt_d = '0;
        end else begin
          rem_d = trial[P] ? rem_sh : trial[P-1:0];
          quo_d = {quo_q[P-2:0], ~trial[P]};
          dnd_d = {dnd_q[P-2:0], 1'b0};
          cnt_d = cnt_q + CB'(1);
        end
      end
      rau_pkg::ST_FIN: begin
        res_d.res_num     = to_field(num_neg_q, num_q);
        res_d.res_den     = to_field(den_neg_q, den_q);
        res_d.equal       = 1'b0;
        res_d.div_by_zero = 1'b0;
        res_d.overflow    = !(fits(num_neg_q, num_q) && fits(den_neg_q, den_q));
      end
      default: ;
    endcase
  end

  assign job_rdy_o = (st_q == rau_pkg::ST_IDLE);
  assign empty_o   = (st_q != rau_pkg::ST_OUT);
  assign res_o     = res_q;

  always_ff @(posedge clk_i) begin
    if (job_vld_i && job_rdy_o) job_q <= job_i;
    p_q <= p_d; t_q <= t_d; t_neg_q <= t_neg_d;
    num_q <= num_d; den_q <= den_d; num_neg_q <= num_neg_d; den_neg_q <= den_neg_d;
    x_q <= x_d; y_q <= y_d; dv_q <= dv_d; rem_q <= rem_d; quo_q <= quo_d; dnd_q <= dnd_d;
    cnt_q <= cnt_d; res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= rau_pkg::ST_IDLE;
      dstart_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      dstart_q <= dstart_d;
    end
  end

endmodule

// ----- rtl/rational_arith_unit_core.sv -----
// Rational arithmetic unit: add, multiply, divide, compare of fractions.
// Compare and divide-by-zero bypass the arithmetic; other requests step through the
// cross products, a sum, Euclid's gcd and, if the gcd exceeds one, two reduction divides.
// Throughput: one request at a time in the back end, set by the shared
// bit-serial divider; the front queue holds two more requests.
// Reset: asynchronous active low, clears queue pointers and sequencer state.
module rational_arith_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rau_pkg::in_t req_i,
  input  logic         push,
  output logic         full,
  output rau_pkg::out_t res_o,
  output logic         empty,
  input  logic         pop
);

  rau_pkg::job_t job;
  logic          job_vld, job_rdy;

  // Front: classify and queue each request.
  rau_front u_front (
    .clk_i, .rst_ni, .req_i, .push_i(push), .full_o(full),
    .job_o(job), .job_vld_o(job_vld), .job_rdy_i(job_rdy)
  );

  // Back: multiply, reduce by gcd, hold result until popped.
  rau_back u_back (
    .clk_i, .rst_ni, .job_i(job), .job_vld_i(job_vld), .job_rdy_o(job_rdy),
    .res_o, .empty_o(empty), .pop_i(pop)
  );

endmodule

// ----- rtl/rau_checker.sv -----
module rau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input rau_pkg::out_t res_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(res_o)) else $error("result changed while waiting");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(res_o.equal && res_o.div_by_zero)) else $error("flags clash");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.div_by_zero) |-> (res_o.res_num == 0 && res_o.res_den == 0
      && !res_o.overflow)) else $error("divide by zero result not zero");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> empty) else $error("second result without new work");

endmodule

bind rational_arith_unit_core rau_checker u_rau_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .res_o
);
